// File: rtl/ddvd_pkg.sv
// ddvd_pkg: shared codes, constants and control struct for the voltage-to-duty block
// no dependencies; imported by every ddvd module

package ddvd_pkg;

   // configuration register indexes and port widths
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIDE_BLEND = 1'd1;

   // control mode codes
   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] MODE_TRACE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FRONT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SIDE  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_ZERO  = 2'd3;

   // side-wall situation codes
   localparam int SIT_W = 2;
   localparam logic [SIT_W-1:0] SIT_RIGHT = 2'd0;
   localparam logic [SIT_W-1:0] SIT_LEFT  = 2'd1;
   localparam logic [SIT_W-1:0] SIT_BOTH  = 2'd2;
   localparam logic [SIT_W-1:0] SIT_NONE  = 2'd3;

   // blend weight in 1/256 units
   localparam int BLEND_W    = 9;
   localparam int BLEND_FULL = 256;

   // duty output format and dead-zone offsets
   localparam int DUTY_W  = 12;
   localparam int OFS_POS = 40;
   localparam int OFS_NEG = 45;
   localparam logic [DUTY_W-1:0] DUTY_IDLE = DUTY_W'(-OFS_NEG);

   // per-item control flags travelling down the pipeline
   typedef struct packed {
      logic valid;
      logic berr;
      logic neg_r;
      logic neg_l;
      logic sat_r;
      logic sat_l;
   } ddvd_ctl_type;

endpackage

// File: rtl/ddvd_front.sv
// ddvd_front: mode select, side-wall blend, sum/difference split, scaling and saturation check
// depends on ddvd_pkg; feeds the first ddvd_cell of the divider chain

module ddvd_front #(
   parameter int VOLT_BITS = 16,
   parameter int DUTY_FULL = 1000,
   parameter int QB        = 10,
   parameter int DW        = VOLT_BITS + 8,
   parameter int RW        = DW + QB
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [ddvd_pkg::MODE_W-1:0]    drive_mode,
   input  logic [ddvd_pkg::BLEND_W-1:0]   side_blend,
   input  logic [ddvd_pkg::SIT_W-1:0]     side_situation,
   input  logic signed [VOLT_BITS-1:0]    sum_trace_mv,
   input  logic signed [VOLT_BITS-1:0]    diff_trace_mv,
   input  logic signed [VOLT_BITS-1:0]    sum_front_mv,
   input  logic signed [VOLT_BITS-1:0]    diff_front_mv,
   input  logic signed [VOLT_BITS-1:0]    diff_side_mv,
   input  logic [VOLT_BITS-2:0]           battery_mv,
   output ddvd_pkg::ddvd_ctl_type         dn_ctl,
   output logic [RW-1:0]                  dn_rem_r,
   output logic [RW-1:0]                  dn_rem_l,
   output logic [DW-1:0]                  dn_dv
);

   import ddvd_pkg::*;

   localparam int PW = RW + 1;

   logic [BLEND_W-1:0]          blend_w;
   logic signed [VOLT_BITS:0]   diff_ab;
   logic signed [VOLT_BITS+10:0] blend_prod;
   logic signed [VOLT_BITS+10:0] blend_full;
   logic signed [VOLT_BITS-1:0] s_sel;
   logic signed [DW-1:0]        d_sel;

   logic                        a_valid_ff;
   logic signed [VOLT_BITS-1:0] a_s_ff;
   logic signed [DW-1:0]        a_d_ff;
   logic [VOLT_BITS-2:0]        a_bat_ff;

   logic signed [DW-1:0]        s256;
   logic signed [DW:0]          num_r;
   logic signed [DW:0]          num_l;
   logic [DW:0]                 mag_r;
   logic [DW:0]                 mag_l;
   logic [PW-1:0]               scl_r_in;
   logic [PW-1:0]               scl_l_in;

   logic                        b_valid_ff;
   logic                        b_neg_r_ff;
   logic                        b_neg_l_ff;
   logic [PW-1:0]               b_scl_r_ff;
   logic [PW-1:0]               b_scl_l_ff;
   logic [VOLT_BITS-2:0]        b_bat_ff;

   logic [PW-1:0]               sat_lim;
   ddvd_pkg::ddvd_ctl_type      ctl_in;
   ddvd_pkg::ddvd_ctl_type      ctl_ff;
   logic [RW-1:0]               rem_r_ff;
   logic [RW-1:0]               rem_l_ff;
   logic [DW-1:0]               dv_ff;

   // side-wall blend: 256*trace + w*(side - trace)
   always_comb begin
      blend_w    = (side_blend > BLEND_W'(BLEND_FULL)) ? BLEND_W'(BLEND_FULL) : side_blend;
      diff_ab    = (VOLT_BITS+1)'(diff_side_mv) - (VOLT_BITS+1)'(diff_trace_mv);
      blend_prod = $signed({1'b0, blend_w}) * diff_ab;
      blend_full = $signed({{3{diff_trace_mv[VOLT_BITS-1]}}, diff_trace_mv, 8'b0}) + blend_prod;
   end

   // sum and scaled difference by mode
   always_comb begin
      s_sel = '0;
      d_sel = '0;
      case (drive_mode)
         MODE_TRACE: begin
            s_sel = sum_trace_mv;
            d_sel = {diff_trace_mv, 8'b0};
         end
         MODE_FRONT: begin
            s_sel = sum_front_mv;
            d_sel = {diff_front_mv, 8'b0};
         end
         MODE_SIDE: begin
            s_sel = sum_trace_mv;
            case (side_situation)
               SIT_RIGHT, SIT_LEFT: d_sel = {diff_side_mv, 8'b0};
               SIT_BOTH:            d_sel = blend_full[DW-1:0];
               default:             d_sel = {diff_trace_mv, 8'b0};
            endcase
         end
         default: begin
            s_sel = '0;
            d_sel = '0;
         end
      endcase
   end

   // stage a: selected voltages
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
      end
      a_s_ff   <= s_sel;
      a_d_ff   <= d_sel;
      a_bat_ff <= battery_mv;
   end

   // right/left split, sign-magnitude and scaling by full duty
   always_comb begin
      s256     = {a_s_ff, 8'b0};
      num_r    = $signed({s256[DW-1], s256}) + $signed({a_d_ff[DW-1], a_d_ff});
      num_l    = $signed({s256[DW-1], s256}) - $signed({a_d_ff[DW-1], a_d_ff});
      mag_r    = num_r[DW] ? (DW+1)'(-num_r) : num_r;
      mag_l    = num_l[DW] ? (DW+1)'(-num_l) : num_l;
      scl_r_in = PW'(mag_r) * PW'(DUTY_FULL);
      scl_l_in = PW'(mag_l) * PW'(DUTY_FULL);
   end

   // stage b: scaled numerators
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_neg_r_ff <= num_r[DW];
      b_neg_l_ff <= num_l[DW];
      b_scl_r_ff <= scl_r_in;
      b_scl_l_ff <= scl_l_in;
      b_bat_ff   <= a_bat_ff;
   end

   // quotient would not fit the chain: saturate
   always_comb begin
      sat_lim      = {1'b0, b_bat_ff, 9'b0, {QB{1'b0}}};
      ctl_in.valid = b_valid_ff;
      ctl_in.berr  = (b_bat_ff == '0);
      ctl_in.neg_r = b_neg_r_ff;
      ctl_in.neg_l = b_neg_l_ff;
      ctl_in.sat_r = (b_scl_r_ff >= sat_lim);
      ctl_in.sat_l = (b_scl_l_ff >= sat_lim);
   end

   // stage c: divider entry
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      rem_r_ff <= b_scl_r_ff[RW-1:0];
      rem_l_ff <= b_scl_l_ff[RW-1:0];
      dv_ff    <= {b_bat_ff, 9'b0};
   end

   assign dn_ctl   = ctl_ff;
   assign dn_rem_r = rem_r_ff;
   assign dn_rem_l = rem_l_ff;
   assign dn_dv    = dv_ff;

endmodule

// File: rtl/ddvd_cell.sv
// ddvd_cell: one restoring division step for the right and left lanes
// depends on ddvd_pkg; chained in the top level, one cell per quotient bit

module ddvd_cell #(
   parameter int DW    = 24,
   parameter int QB    = 10,
   parameter int RW    = DW + QB,
   parameter int SHIFT = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ddvd_pkg::ddvd_ctl_type up_ctl,
   input  logic [RW-1:0]          up_rem_r,
   input  logic [RW-1:0]          up_rem_l,
   input  logic [QB-1:0]          up_quo_r,
   input  logic [QB-1:0]          up_quo_l,
   input  logic [DW-1:0]          up_dv,
   output ddvd_pkg::ddvd_ctl_type dn_ctl,
   output logic [RW-1:0]          dn_rem_r,
   output logic [RW-1:0]          dn_rem_l,
   output logic [QB-1:0]          dn_quo_r,
   output logic [QB-1:0]          dn_quo_l,
   output logic [DW-1:0]          dn_dv
);

   import ddvd_pkg::*;

   logic [RW-1:0]  trial;
   logic [QB-1:0]  qbit;
   logic           ge_r;
   logic           ge_l;
   logic [RW-1:0]  rem_r_in;
   logic [RW-1:0]  rem_l_in;
   logic [QB-1:0]  quo_r_in;
   logic [QB-1:0]  quo_l_in;

   ddvd_ctl_type   ctl_ff;
   logic [RW-1:0]  rem_r_ff;
   logic [RW-1:0]  rem_l_ff;
   logic [QB-1:0]  quo_r_ff;
   logic [QB-1:0]  quo_l_ff;
   logic [DW-1:0]  dv_ff;

   // compare against shifted divisor and subtract
   always_comb begin
      trial    = RW'(up_dv) << SHIFT;
      qbit     = QB'(1) << SHIFT;
      ge_r     = (up_rem_r >= trial);
      ge_l     = (up_rem_l >= trial);
      rem_r_in = ge_r ? (up_rem_r - trial) : up_rem_r;
      rem_l_in = ge_l ? (up_rem_l - trial) : up_rem_l;
      quo_r_in = ge_r ? (up_quo_r | qbit) : up_quo_r;
      quo_l_in = ge_l ? (up_quo_l | qbit) : up_quo_l;
   end

   // hand over to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= up_ctl;
      end
      rem_r_ff <= rem_r_in;
      rem_l_ff <= rem_l_in;
      quo_r_ff <= quo_r_in;
      quo_l_ff <= quo_l_in;
      dv_ff    <= up_dv;
   end

   assign dn_ctl   = ctl_ff;
   assign dn_rem_r = rem_r_ff;
   assign dn_rem_l = rem_l_ff;
   assign dn_quo_r = quo_r_ff;
   assign dn_quo_l = quo_l_ff;
   assign dn_dv    = dv_ff;

endmodule

// File: rtl/ddvd_back.sv
// ddvd_back: clamp, sign, dead-zone offset and result register
// depends on ddvd_pkg; takes the last ddvd_cell of the chain

module ddvd_back #(
   parameter int DUTY_FULL = 1000,
   parameter int QB        = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ddvd_pkg::ddvd_ctl_type        up_ctl,
   input  logic [QB-1:0]                 up_quo_r,
   input  logic [QB-1:0]                 up_quo_l,
   output logic                          rsp_valid,
   output logic [ddvd_pkg::DUTY_W-1:0]   rsp_duty_right,
   output logic [ddvd_pkg::DUTY_W-1:0]   rsp_duty_left,
   output logic                          rsp_battery_error
);

   import ddvd_pkg::*;

   localparam int EW = (QB + 2 > DUTY_W) ? QB + 2 : DUTY_W;

   logic [DUTY_W-1:0] duty_r_in;
   logic [DUTY_W-1:0] duty_l_in;
   logic              valid_ff;
   logic [DUTY_W-1:0] duty_r_ff;
   logic [DUTY_W-1:0] duty_l_ff;
   logic              berr_ff;

   // clamped magnitude with sign and offset, cut to the output width
   function automatic logic [DUTY_W-1:0] make_duty(input logic [QB-1:0] quo,
                                                   input logic sat,
                                                   input logic neg,
                                                   input logic berr);
      logic [QB-1:0]        mag;
      logic signed [EW-1:0] val;
      if (berr) begin
         mag = '0;
      end else if (sat || (quo > QB'(DUTY_FULL))) begin
         mag = QB'(DUTY_FULL);
      end else begin
         mag = quo;
      end
      if (!neg && (mag != '0)) begin
         val = $signed(EW'(mag)) + EW'(OFS_POS);
      end else if (neg) begin
         val = -$signed(EW'(mag)) - EW'(OFS_NEG);
      end else begin
         val = -EW'(OFS_NEG);
      end
      return val[DUTY_W-1:0];
   endfunction

   always_comb begin
      duty_r_in = make_duty(up_quo_r, up_ctl.sat_r, up_ctl.neg_r, up_ctl.berr);
      duty_l_in = make_duty(up_quo_l, up_ctl.sat_l, up_ctl.neg_l, up_ctl.berr);
   end

   // result register, strobe for one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_ctl.valid;
      end
      duty_r_ff <= duty_r_in;
      duty_l_ff <= duty_l_in;
      berr_ff   <= up_ctl.berr;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_duty_right    = duty_r_ff;
   assign rsp_duty_left     = duty_l_ff;
   assign rsp_battery_error = berr_ff;

endmodule

// File: rtl/diff_drive_voltage_to_duty_core.sv
// diff_drive_voltage_to_duty_core: top level of the voltage-to-duty converter
// depends on ddvd_pkg, ddvd_front, ddvd_cell and ddvd_back
//
// Usage: each control tick, drive the req_ voltages and the battery reading and
// raise start. A transfer takes place on every clock edge with start high and
// busy low; busy stays low, so a new tick may be given every cycle.
// Results come out in order on the rsp_ ports, each for exactly one cycle with
// rsp_valid high; the receiver cannot hold them off and must take them then.
// From the request edge to the result edge a tick passes through three front
// stages (select/blend, scaling, saturation check), one divider cell per
// quotient bit (QB, the number of bits of DUTY_FULL), and the output
// register. Throughput is one tick per cycle as every stage and cell takes a
// new item each clock.
// Configuration is written through csr_wr_en, csr_index and csr_wdata; write
// only while no tick is in flight. Synchronous reset clears all valid flags
// (in-flight ticks are dropped) and sets the drive mode to trajectory and
// side_blend to 128.

module diff_drive_voltage_to_duty_core #(
   parameter int VOLT_BITS = 16,
   parameter int DUTY_FULL = 1000
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [ddvd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ddvd_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            start,
   output logic                            busy,
   input  logic [ddvd_pkg::SIT_W-1:0]      req_side_situation,
   input  logic signed [VOLT_BITS-1:0]     req_sum_trace_mv,
   input  logic signed [VOLT_BITS-1:0]     req_diff_trace_mv,
   input  logic signed [VOLT_BITS-1:0]     req_sum_front_mv,
   input  logic signed [VOLT_BITS-1:0]     req_diff_front_mv,
   input  logic signed [VOLT_BITS-1:0]     req_diff_side_mv,
   input  logic [VOLT_BITS-2:0]            req_battery_mv,
   output logic                            rsp_valid,
   output logic signed [ddvd_pkg::DUTY_W-1:0] rsp_duty_right,
   output logic signed [ddvd_pkg::DUTY_W-1:0] rsp_duty_left,
   output logic                            rsp_battery_error
);

   import ddvd_pkg::*;

   localparam int QB  = $clog2(DUTY_FULL + 1);
   localparam int DW  = VOLT_BITS + 8;
   localparam int RW  = DW + QB;
   localparam int LAT = QB + 4;

   logic [MODE_W-1:0]  drive_mode_ff;
   logic [BLEND_W-1:0] side_blend_ff;
   logic               accept;

   ddvd_ctl_type  ctl_w   [QB+1];
   logic [RW-1:0] rem_r_w [QB+1];
   logic [RW-1:0] rem_l_w [QB+1];
   logic [QB-1:0] quo_r_w [QB+1];
   logic [QB-1:0] quo_l_w [QB+1];
   logic [DW-1:0] dv_w    [QB+1];

   logic [DUTY_W-1:0] duty_r;
   logic [DUTY_W-1:0] duty_l;

   // every stage takes a transfer each cycle
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         drive_mode_ff <= MODE_TRACE;
         side_blend_ff <= BLEND_W'(128);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DRIVE_MODE: drive_mode_ff <= csr_wdata[MODE_W-1:0];
            CSR_SIDE_BLEND: side_blend_ff <= csr_wdata[BLEND_W-1:0];
            default: begin
               drive_mode_ff <= drive_mode_ff;
            end
         endcase
      end
   end

   // front stages
   ddvd_front #(
      .VOLT_BITS (VOLT_BITS),
      .DUTY_FULL (DUTY_FULL),
      .QB        (QB),
      .DW        (DW),
      .RW        (RW)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .drive_mode     (drive_mode_ff),
      .side_blend     (side_blend_ff),
      .side_situation (req_side_situation),
      .sum_trace_mv   (req_sum_trace_mv),
      .diff_trace_mv  (req_diff_trace_mv),
      .sum_front_mv   (req_sum_front_mv),
      .diff_front_mv  (req_diff_front_mv),
      .diff_side_mv   (req_diff_side_mv),
      .battery_mv     (req_battery_mv),
      .dn_ctl         (ctl_w[0]),
      .dn_rem_r       (rem_r_w[0]),
      .dn_rem_l       (rem_l_w[0]),
      .dn_dv          (dv_w[0])
   );

   assign quo_r_w[0] = '0;
   assign quo_l_w[0] = '0;

   // divider chain, most significant quotient bit first
   for (genvar j = 0; j < QB; j++) begin : g_cell
      ddvd_cell #(
         .DW    (DW),
         .QB    (QB),
         .RW    (RW),
         .SHIFT (QB - 1 - j)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_ctl   (ctl_w[j]),
         .up_rem_r (rem_r_w[j]),
         .up_rem_l (rem_l_w[j]),
         .up_quo_r (quo_r_w[j]),
         .up_quo_l (quo_l_w[j]),
         .up_dv    (dv_w[j]),
         .dn_ctl   (ctl_w[j+1]),
         .dn_rem_r (rem_r_w[j+1]),
         .dn_rem_l (rem_l_w[j+1]),
         .dn_quo_r (quo_r_w[j+1]),
         .dn_quo_l (quo_l_w[j+1]),
         .dn_dv    (dv_w[j+1])
      );
   end

   // clamp, offset and result register
   ddvd_back #(
      .DUTY_FULL (DUTY_FULL),
      .QB        (QB)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .up_ctl            (ctl_w[QB]),
      .up_quo_r          (quo_r_w[QB]),
      .up_quo_l          (quo_l_w[QB]),
      .rsp_valid         (rsp_valid),
      .rsp_duty_right    (duty_r),
      .rsp_duty_left     (duty_l),
      .rsp_battery_error (rsp_battery_error)
   );

   assign rsp_duty_right = duty_r;
   assign rsp_duty_left  = duty_l;

`ifndef ASSERT_OFF
   // every request comes out after the fixed latency
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_valid)
      else $error("request transfer without result after fixed latency");

   // no result without a request the fixed latency before
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LAT))
      else $error("result transfer without matching request");

   // a flat battery gives the idle duty on both sides
   a_berr_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_battery_error) |->
         (duty_r == DUTY_IDLE) && (duty_l == DUTY_IDLE))
      else $error("battery error without idle duty");
`endif

endmodule

// File: tb/sv/diff_drive_voltage_to_duty_core_tb.sv
// diff_drive_voltage_to_duty_core_tb: self-checking bench for the voltage-to-duty core
// directed table then randomised control ticks under several register settings
// depends on ddvd_pkg and diff_drive_voltage_to_duty_core

module diff_drive_voltage_to_duty_core_tb;
   import ddvd_pkg::*;

   localparam int VOLT_BITS = 16;
   localparam int DUTY_FULL = 1000;
   localparam int N_DIR     = 26;
   localparam int N_PHASE   = 12;
   localparam int PHASE_LEN = 155;
   localparam int TAIL_WAIT = 24;
   localparam int CYCLE_CAP = 200000;

   // one control tick at the port widths
   typedef struct {
      logic [SIT_W-1:0]            sit;
      logic signed [VOLT_BITS-1:0] sum_trace;
      logic signed [VOLT_BITS-1:0] diff_trace;
      logic signed [VOLT_BITS-1:0] sum_front;
      logic signed [VOLT_BITS-1:0] diff_front;
      logic signed [VOLT_BITS-1:0] diff_side;
      logic [VOLT_BITS-2:0]        battery;
   } tick_type;

   // one pair of motor duties
   typedef struct {
      logic signed [DUTY_W-1:0] right;
      logic signed [DUTY_W-1:0] left;
      logic                     berr;
   } duty_type;

   // directed row: register setting, tick fields, optional typed-in duties
   typedef struct {
      int mode;
      int blend;
      int sit;
      int st;
      int dt;
      int sf;
      int df;
      int ds;
      int bat;
      bit typed;
      int er;
      int el;
      int eb;
   } dir_row_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_wr_en;
   logic [CSR_IDX_W-1:0]            csr_index;
   logic [CSR_DATA_W-1:0]           csr_wdata;
   logic                            start;
   logic                            busy;
   logic [SIT_W-1:0]                req_side_situation;
   logic signed [VOLT_BITS-1:0]     req_sum_trace_mv;
   logic signed [VOLT_BITS-1:0]     req_diff_trace_mv;
   logic signed [VOLT_BITS-1:0]     req_sum_front_mv;
   logic signed [VOLT_BITS-1:0]     req_diff_front_mv;
   logic signed [VOLT_BITS-1:0]     req_diff_side_mv;
   logic [VOLT_BITS-2:0]            req_battery_mv;
   logic                            rsp_valid;
   logic signed [DUTY_W-1:0]        rsp_duty_right;
   logic signed [DUTY_W-1:0]        rsp_duty_left;
   logic                            rsp_battery_error;

   // bench copy of the registers, as they stand after reset
   logic [MODE_W-1:0]  cur_mode  = MODE_TRACE;
   logic [BLEND_W-1:0] cur_blend = BLEND_W'(128);

   duty_type    duties_due[$];
   int          n_bad  = 0;
   int          cycles = 0;
   dir_row_type dir_rows [N_DIR];

   diff_drive_voltage_to_duty_core #(
      .VOLT_BITS(VOLT_BITS),
      .DUTY_FULL(DUTY_FULL)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .start             (start),
      .busy              (busy),
      .req_side_situation(req_side_situation),
      .req_sum_trace_mv  (req_sum_trace_mv),
      .req_diff_trace_mv (req_diff_trace_mv),
      .req_sum_front_mv  (req_sum_front_mv),
      .req_diff_front_mv (req_diff_front_mv),
      .req_diff_side_mv  (req_diff_side_mv),
      .req_battery_mv    (req_battery_mv),
      .rsp_valid         (rsp_valid),
      .rsp_duty_right    (rsp_duty_right),
      .rsp_duty_left     (rsp_duty_left),
      .rsp_battery_error (rsp_battery_error)
   );

   always #4 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      n_bad++;
   endtask

   // one side: exact quotient truncated toward zero, clamp, dead-zone offset
   function automatic logic signed [DUTY_W-1:0] scale_duty(input longint num256,
                                                           input longint bat,
                                                           input bit     berr);
      longint d;
      d = 0;
      if (!berr) begin
         d = (num256 * DUTY_FULL) / (512 * bat);
         if (d > DUTY_FULL) d = DUTY_FULL;
         if (d < -DUTY_FULL) d = -DUTY_FULL;
      end
      if (d > 0) begin
         d = d + OFS_POS;
      end else begin
         d = d - OFS_NEG;
      end
      return d[DUTY_W-1:0];
   endfunction

   // duties for one tick under the current register setting
   function automatic duty_type predict_duty(input tick_type t);
      longint   s256;
      longint   d256;
      longint   w;
      longint   bat;
      duty_type r;
      s256 = 0;
      d256 = 0;
      bat  = t.battery;
      w    = (cur_blend > BLEND_FULL) ? BLEND_FULL : cur_blend;
      case (cur_mode)
         MODE_TRACE: begin
            s256 = longint'(t.sum_trace) * 256;
            d256 = longint'(t.diff_trace) * 256;
         end
         MODE_FRONT: begin
            s256 = longint'(t.sum_front) * 256;
            d256 = longint'(t.diff_front) * 256;
         end
         MODE_SIDE: begin
            s256 = longint'(t.sum_trace) * 256;
            if (t.sit == SIT_RIGHT || t.sit == SIT_LEFT) begin
               d256 = longint'(t.diff_side) * 256;
            end else if (t.sit == SIT_BOTH) begin
               d256 = w * longint'(t.diff_side) + (BLEND_FULL - w) * longint'(t.diff_trace);
            end else begin
               d256 = longint'(t.diff_trace) * 256;
            end
         end
         default: begin
            s256 = 0;
            d256 = 0;
         end
      endcase
      r.berr  = (bat == 0);
      r.right = scale_duty(s256 + d256, bat, r.berr);
      r.left  = scale_duty(s256 - d256, bat, r.berr);
      return r;
   endfunction

   // drive one tick, optionally after a short gap, and log its duties on transfer
   task automatic issue_tick(input tick_type t, input bit typed, input duty_type due,
                             input bit may_idle);
      int       gap;
      duty_type want;
      gap = 0;
      if (may_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 3);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start              <= 1'b1;
      req_side_situation <= t.sit;
      req_sum_trace_mv   <= t.sum_trace;
      req_diff_trace_mv  <= t.diff_trace;
      req_sum_front_mv   <= t.sum_front;
      req_diff_front_mv  <= t.diff_front;
      req_diff_side_mv   <= t.diff_side;
      req_battery_mv     <= t.battery;
      want = typed ? due : predict_duty(t);
      @(negedge clock);
      while (busy !== 1'b0) @(negedge clock);
      @(posedge clock);
      duties_due.push_back(want);
   endtask

   // drain, then write both registers
   task automatic apply_config(input logic [MODE_W-1:0] mode, input logic [BLEND_W-1:0] blend);
      start <= 1'b0;
      while (duties_due.size() != 0) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_DRIVE_MODE;
      // upper data bits are don't-care for the mode register
      csr_wdata <= {7'($urandom), mode};
      @(posedge clock);
      cur_mode  = mode;
      csr_index <= CSR_SIDE_BLEND;
      csr_wdata <= blend;
      @(posedge clock);
      cur_blend = blend;
      csr_wr_en <= 1'b0;
   endtask

   function automatic tick_type random_tick();
      tick_type t;
      int       style;
      style = $urandom_range(0, 19);
      t.sit = SIT_W'($urandom_range(0, 3));
      if (style < 3) begin
         // any bit pattern
         t.sum_trace  = VOLT_BITS'($urandom);
         t.diff_trace = VOLT_BITS'($urandom);
         t.sum_front  = VOLT_BITS'($urandom);
         t.diff_front = VOLT_BITS'($urandom);
         t.diff_side  = VOLT_BITS'($urandom);
         t.battery    = (VOLT_BITS-1)'($urandom);
      end else begin
         // plausible drive voltages against a plausible, flat or very low battery
         t.sum_trace  = VOLT_BITS'(int'($urandom_range(0, 16000)) - 8000);
         t.diff_trace = VOLT_BITS'(int'($urandom_range(0, 8000)) - 4000);
         t.sum_front  = VOLT_BITS'(int'($urandom_range(0, 16000)) - 8000);
         t.diff_front = VOLT_BITS'(int'($urandom_range(0, 8000)) - 4000);
         t.diff_side  = VOLT_BITS'(int'($urandom_range(0, 8000)) - 4000);
         if (style == 3) begin
            t.battery = '0;
         end else if (style == 4) begin
            t.battery = (VOLT_BITS-1)'($urandom_range(1, 64));
         end else begin
            t.battery = (VOLT_BITS-1)'($urandom_range(3000, 9000));
         end
      end
      return t;
   endfunction

   // monitor: each strobed result against the oldest expectation
   always @(negedge clock) begin
      duty_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         if (duties_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected result r=%0d l=%0d err=%b",
                                    rsp_duty_right, rsp_duty_left, rsp_battery_error));
         end else begin
            want = duties_due.pop_front();
            if (rsp_duty_right !== want.right || rsp_duty_left !== want.left ||
                rsp_battery_error !== want.berr) begin
               flag_mismatch($sformatf("got r=%0d l=%0d err=%b, want r=%0d l=%0d err=%b",
                                       rsp_duty_right, rsp_duty_left, rsp_battery_error,
                                       want.right, want.left, want.berr));
            end
         end
      end
   end

   initial begin
      tick_type    t;
      duty_type    due;
      dir_row_type r;
      logic [MODE_W-1:0]  mode;
      logic [BLEND_W-1:0] blend;

      // directed ticks: mode, blend, sit, sum/diff trace, sum/diff front, diff side,
      // battery, typed flag, expected right, left, error
      dir_rows = '{
         '{MODE_TRACE, 128, SIT_RIGHT,      0,      0,   0,   0, 0,     0, 1,   -45,   -45, 1},
         '{MODE_TRACE, 128, SIT_LEFT,   32767,      0,   0,   0, 0,     1, 1,  1040,  1040, 0},
         '{MODE_TRACE, 128, SIT_BOTH,  -32768,      0,   0,   0, 0,     1, 1, -1045, -1045, 0},
         '{MODE_TRACE, 128, SIT_NONE,       0,  32767,   0,   0, 0,     1, 1,  1040, -1045, 0},
         '{MODE_TRACE, 128, SIT_RIGHT,      0, -32768,   0,   0, 0,     1, 1, -1045,  1040, 0},
         '{MODE_TRACE, 128, SIT_RIGHT,  32767,  32767,   0,   0, 0, 32767, 1,  1040,   -45, 0},
         '{MODE_TRACE, 128, SIT_RIGHT, -32768, -32768,   0,   0, 0, 32767, 1, -1045,   -45, 0},
         '{MODE_TRACE, 128, SIT_RIGHT,      0,      0,   0,   0, 0, 32767, 1,   -45,   -45, 0},
         '{MODE_TRACE, 128, SIT_RIGHT,      1,      0,   0,   0, 0,     1, 1,   540,   540, 0},
         '{MODE_TRACE, 128, SIT_RIGHT,     -1,      0,   0,   0, 0,     1, 1,  -545,  -545, 0},
         '{MODE_TRACE, 128, SIT_RIGHT,      1,      0,   0,   0, 0,  1000, 1,   -45,   -45, 0},
         '{MODE_TRACE, 128, SIT_RIGHT,     -1,      0,   0,   0, 0,  1000, 1,   -45,   -45, 0},
         '{MODE_TRACE, 128, SIT_RIGHT,      3,      0,   0,   0, 0,  1000, 1,    41,    41, 0},
         '{MODE_FRONT, 128, SIT_BOTH,     100,    100, 32767, -32768, 7, 1, 1, -545, 1040, 0},
         '{MODE_FRONT, 128, SIT_BOTH,   32767,      0,   0,   0, 0,     1, 1,   -45,   -45, 0},
         '{MODE_SIDE,  128, SIT_RIGHT,      0,  -5000,   0,   0, 1000, 1000, 1, 540, -545, 0},
         '{MODE_SIDE,  128, SIT_LEFT,       0,  -5000,   0,   0, 1000, 1000, 1, 540, -545, 0},
         '{MODE_SIDE,  128, SIT_NONE,       0,  -2000,   0,   0, 1000, 1000, 1, -1045, 1040, 0},
         '{MODE_SIDE,  128, SIT_BOTH,       0,  -3000,   0,   0, 1000, 1000, 1, -545, 540, 0},
         '{MODE_SIDE,    0, SIT_BOTH,       0,  -3000,   0,   0, 1000, 1000, 1, -1045, 1040, 0},
         '{MODE_SIDE,  256, SIT_BOTH,       0,  -3000,   0,   0, 1000, 1000, 1, 540, -545, 0},
         '{MODE_SIDE,  511, SIT_BOTH,       0,  -3000,   0,   0, 1000, 1000, 1, 540, -545, 0},
         '{MODE_SIDE,    1, SIT_BOTH,       0,      0,   0,   0, 1,     1, 1,    41,   -46, 0},
         '{MODE_SIDE,  200, SIT_BOTH,    1234,   4321, -99, 55, -777, 3700, 0,     0,     0, 0},
         '{MODE_ZERO,  200, SIT_BOTH,   30000,  -9000, 500, 600, 70,    5, 1,   -45,   -45, 0},
         '{MODE_ZERO,  200, SIT_NONE,   30000,  -9000, 500, 600, 70,    0, 1,   -45,   -45, 1}
      };

      // known values on every input while reset is held
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_index          <= CSR_DRIVE_MODE;
      csr_wdata          <= '0;
      start              <= 1'b0;
      req_side_situation <= SIT_RIGHT;
      req_sum_trace_mv   <= '0;
      req_diff_trace_mv  <= '0;
      req_sum_front_mv   <= '0;
      req_diff_front_mv  <= '0;
      req_diff_side_mv   <= '0;
      req_battery_mv     <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int i = 0; i < N_DIR; i++) begin
         r = dir_rows[i];
         if (MODE_W'(r.mode) != cur_mode || BLEND_W'(r.blend) != cur_blend)
            apply_config(MODE_W'(r.mode), BLEND_W'(r.blend));
         t.sit        = SIT_W'(r.sit);
         t.sum_trace  = VOLT_BITS'(r.st);
         t.diff_trace = VOLT_BITS'(r.dt);
         t.sum_front  = VOLT_BITS'(r.sf);
         t.diff_front = VOLT_BITS'(r.df);
         t.diff_side  = VOLT_BITS'(r.ds);
         t.battery    = (VOLT_BITS-1)'(r.bat);
         due.right    = DUTY_W'(r.er);
         due.left     = DUTY_W'(r.el);
         due.berr     = r.eb[0];
         issue_tick(t, r.typed, due, 1'b1);
      end

      // random phases, each under its own register setting
      for (int p = 0; p < N_PHASE; p++) begin
         case (p)
            0: begin mode = MODE_TRACE; blend = BLEND_W'(128); end
            1: begin mode = MODE_FRONT; blend = BLEND_W'(0); end
            2: begin mode = MODE_ZERO;  blend = BLEND_W'(300); end
            3: begin mode = MODE_SIDE;  blend = BLEND_W'(128); end
            4: begin mode = MODE_SIDE;  blend = BLEND_W'(0); end
            5: begin mode = MODE_SIDE;  blend = BLEND_W'(BLEND_FULL); end
            6: begin mode = MODE_SIDE;  blend = BLEND_W'(511); end
            default: begin
               mode  = ($urandom_range(0, 1) == 0) ? MODE_SIDE : MODE_W'($urandom_range(0, 3));
               blend = BLEND_W'($urandom_range(0, 511));
            end
         endcase
         apply_config(mode, blend);
         // the final phase runs back to back
         for (int i = 0; i < PHASE_LEN; i++)
            issue_tick(random_tick(), 1'b0, due, p != N_PHASE - 1);
      end

      // drain and let the pipeline run dry
      start <= 1'b0;
      while (duties_due.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
      if (duties_due.size() != 0)
         flag_mismatch($sformatf("%0d expected results never arrived", duties_due.size()));

      if (n_bad == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/ddvd_pkg.sv
rtl/ddvd_front.sv
rtl/ddvd_cell.sv
rtl/ddvd_back.sv
rtl/diff_drive_voltage_to_duty_core.sv
tb/sv/diff_drive_voltage_to_duty_core_tb.sv
